// ===== sv/dsh_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes, fixed field widths and controller/datapath interface structs.
package dsh_pkg;

  localparam int CMD_W       = 2;
  localparam int COORD_W     = 8;
  localparam int STEP_W      = 9;
  localparam int OFFSET_W    = 32;
  localparam int OUT_W       = 32;
  // widest grid axis supported; coordinates are zero-extended to this first
  localparam int MAX_AXIS_W  = 12;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SQUARE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DIAMOND = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch the accepted transaction
    logic rd_first;   // read first neighbour pair (or the point itself)
    logic rd_second;  // read second neighbour pair
    logic sum_en;     // form the four-neighbour sum
    logic finish;     // write back (not for a read) and present the result
    logic clear_en;   // post-reset clearing pass
  } dsh_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             clear_last;
  } dsh_sts_t;

endpackage

// ===== sv/dsh_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine for the height map block.
module dsh_ctrl
  import dsh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CMD_W-1:0] command,
  input  dsh_sts_t         sts,
  output dsh_ctl_t         ctl,
  output logic             busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_RD0   = 3'd2;
  localparam logic [2:0] S_RD1   = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (command == CMD_LOAD) ? S_WR : S_RD0;
        end
      end
      S_CLEAR: begin
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_RD0:   state_next = (sts.cmd == CMD_READ) ? S_WR : S_RD1;
      S_RD1:   state_next = S_SUM;
      S_SUM:   state_next = S_WR;
      S_WR:    state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy          = (state != S_IDLE);
  assign ctl.capture   = (state == S_IDLE) && start;
  assign ctl.rd_first  = (state == S_RD0);
  assign ctl.rd_second = (state == S_RD1);
  assign ctl.sum_en    = (state == S_SUM);
  assign ctl.finish    = (state == S_WR);
  assign ctl.clear_en  = (state == S_CLEAR);

endmodule

// ===== sv/dsh_datapath.sv =====
`timescale 1ns / 1ps
// Height store, neighbour addressing, averaging and saturation.
module dsh_datapath
  import dsh_pkg::*;
#(
  parameter int X_BITS      = 8,
  parameter int Y_BITS      = 8,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dsh_ctl_t                   ctl,
  output dsh_sts_t                   sts,
  input  logic [CMD_W-1:0]           command,
  input  logic [COORD_W-1:0]         column,
  input  logic [COORD_W-1:0]         row,
  input  logic [STEP_W-1:0]          step_size,
  input  logic signed [OFFSET_W-1:0] offset_value,
  output logic                       done,
  output logic signed [OUT_W-1:0]    sample_out,
  output logic                       saturated
);

  localparam int AB    = X_BITS + Y_BITS;
  localparam int DEPTH = 1 << AB;
  localparam int SB    = SAMPLE_BITS;
  // wide enough for an average plus a 32-bit offset with room to spare
  localparam int AW    = ((SB > OFFSET_W) ? SB : OFFSET_W) + 3;
  localparam logic signed [AW-1:0] SMAX = {{(AW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [AW-1:0] SMIN = ~SMAX;

  logic signed [SB-1:0] store [DEPTH];

  // captured transaction
  logic [CMD_W-1:0]           cmd;
  logic [X_BITS-1:0]          px;
  logic [Y_BITS-1:0]          py;
  logic [X_BITS-1:0]          hx;
  logic [Y_BITS-1:0]          hy;
  logic signed [OFFSET_W-1:0] off;

  logic [MAX_AXIS_W-1:0] col_w, row_w, half_w;

  assign col_w  = MAX_AXIS_W'(column);
  assign row_w  = MAX_AXIS_W'(row);
  assign half_w = MAX_AXIS_W'(step_size[STEP_W-1:1]);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd <= command;
      px  <= col_w[X_BITS-1:0];
      py  <= row_w[Y_BITS-1:0];
      hx  <= half_w[X_BITS-1:0];
      hy  <= half_w[Y_BITS-1:0];
      off <= offset_value;
    end
  end

  // neighbour coordinates, wrapping on the torus
  logic [X_BITS-1:0] xm, xp;
  logic [Y_BITS-1:0] ym, yp;
  assign xm = px - hx;
  assign xp = px + hx;
  assign ym = py - hy;
  assign yp = py + hy;

  logic [AB-1:0] ra0, ra1, pt_addr;
  assign pt_addr = {py, px};

  always_comb begin
    ra0 = pt_addr;
    ra1 = pt_addr;
    if (ctl.rd_second) begin
      if (cmd == CMD_SQUARE) begin
        ra0 = {yp, xm};
        ra1 = {yp, xp};
      end else begin
        ra0 = {ym, px};
        ra1 = {yp, px};
      end
    end else if (cmd == CMD_SQUARE) begin
      ra0 = {ym, xm};
      ra1 = {ym, xp};
    end else if (cmd == CMD_DIAMOND) begin
      ra0 = {py, xm};
      ra1 = {py, xp};
    end
  end

  logic signed [SB-1:0] q0, q1;
  logic                 rd_en;
  assign rd_en = ctl.rd_first | ctl.rd_second;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q0 <= store[ra0];
      q1 <= store[ra1];
    end
  end

  // clearing pass counter
  logic [AB-1:0] clr_addr;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clear_en) begin
      clr_addr <= clr_addr + AB'(1);
    end
  end

  assign sts.cmd        = cmd;
  assign sts.clear_last = ctl.clear_en && (clr_addr == {AB{1'b1}});

  // neighbour sum
  logic signed [SB:0]   ab_sum;
  logic signed [SB+1:0] total;
  always_ff @(posedge clk) begin
    if (ctl.rd_second) begin
      ab_sum <= (SB+1)'(q0) + (SB+1)'(q1);
    end
    if (ctl.sum_en) begin
      total <= (SB+2)'(ab_sum) + (SB+2)'(q0) + (SB+2)'(q1);
    end
  end

  // average (floor divide by four), add offset, saturate
  logic signed [SB+1:0] quarter;
  logic signed [AW-1:0] avg_w, raw, clipped, rd_w;
  logic                 clip_hit;
  assign quarter = total >>> 2;
  assign avg_w   = (cmd == CMD_LOAD) ? '0 : AW'(quarter);
  assign raw     = avg_w + AW'(off);
  assign rd_w    = AW'(q0);

  always_comb begin
    clipped  = raw;
    clip_hit = 1'b0;
    if (raw > SMAX) begin
      clipped  = SMAX;
      clip_hit = 1'b1;
    end else if (raw < SMIN) begin
      clipped  = SMIN;
      clip_hit = 1'b1;
    end
  end

  // single write port: clearing pass or write-back
  logic          we;
  logic [AB-1:0] wa;
  logic [SB-1:0] wd;
  assign we = ctl.clear_en | (ctl.finish && (cmd != CMD_READ));
  assign wa = ctl.clear_en ? clr_addr : pt_addr;
  assign wd = ctl.clear_en ? '0 : clipped[SB-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      store[wa] <= wd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      if (cmd == CMD_READ) begin
        sample_out <= rd_w[OUT_W-1:0];
        saturated  <= 1'b0;
      end else begin
        sample_out <= clipped[OUT_W-1:0];
        saturated  <= clip_hit;
      end
    end
  end

endmodule

// ===== sv/diamond_square_heightmap_step_top.sv =====
`timescale 1ns / 1ps
// Top level of the diamond-square height map step block.
//
// Toroidal 2^X_BITS by 2^Y_BITS height map of signed fixed-point samples
// (Q16.16 at the default width). A transaction is taken when start is high and
// busy is low; its one result appears on sample_out/saturated for exactly one
// cycle with done high, and the receiver cannot hold it off, so capture it
// when done is seen. After reset the block runs a clearing pass that zeroes
// the store one entry a cycle, with busy held high until the last entry is
// cleared. A load goes straight to write-back; a read takes one read of the
// point, then write-back; a square or diamond step is paced by the store,
// which has one write port and two read ports: the four neighbours are read
// as two pairs, then summed, then written back. A new transaction may be
// started in the very cycle in which done is high.
module diamond_square_heightmap_step_top
  import dsh_pkg::*;
#(
  parameter int X_BITS      = 8,
  parameter int Y_BITS      = 8,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [CMD_W-1:0]           command,
  input  logic [COORD_W-1:0]         column,
  input  logic [COORD_W-1:0]         row,
  input  logic [STEP_W-1:0]          step_size,
  input  logic signed [OFFSET_W-1:0] offset_value,
  output logic                       done,
  output logic signed [OUT_W-1:0]    sample_out,
  output logic                       saturated
);

  dsh_ctl_t ctl;
  dsh_sts_t sts;

  // sequencer: clearing pass, read phases, sum, write-back
  dsh_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy)
  );

  // store, addressing, arithmetic and result register
  dsh_datapath #(
    .X_BITS      (X_BITS),
    .Y_BITS      (Y_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .command      (command),
    .column       (column),
    .row          (row),
    .step_size    (step_size),
    .offset_value (offset_value),
    .done         (done),
    .sample_out   (sample_out),
    .saturated    (saturated)
  );

  // an accepted transaction always leaves the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not make the block busy");

  // a result only follows a write-back cycle of a busy block
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && $past(ctl.finish))
    else $error("result strobe without a preceding write-back");

  // results are single-cycle strobes, never back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // no transaction work while the clearing pass runs
  a_clear_exclusive: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_en |-> !(ctl.rd_first || ctl.rd_second || ctl.finish || ctl.capture))
    else $error("clearing pass overlaps transaction work");

endmodule
